FILE: design/memory_access_region_classifier_defines.svh
// Assertion macros shared by the region classifier RTL.
`ifndef MEMORY_ACCESS_REGION_CLASSIFIER_DEFINES_SVH
`define MEMORY_ACCESS_REGION_CLASSIFIER_DEFINES_SVH

// Checks a consequent in the same cycle as its antecedent.
`define MARC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("region classifier check failed");

// Checks a consequent in the cycle after its antecedent.
`define MARC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("region classifier check failed");

`endif

FILE: design/marc_pkg.sv
// Types and constants of the memory access region classifier.
package marc_pkg;

	localparam int NUM_REGIONS = 6;
	localparam int IN_TDATA_W  = 264;
	localparam int OUT_TDATA_W = 264;

	localparam logic REQ_ACCESS = 1'b0;
	localparam logic REQ_UPDATE = 1'b1;

	localparam logic [2:0] RG_CODE    = 3'd0;
	localparam logic [2:0] RG_PLT     = 3'd1;
	localparam logic [2:0] RG_STACK   = 3'd2;
	localparam logic [2:0] RG_LINEAR  = 3'd3;
	localparam logic [2:0] RG_VMCTX   = 3'd4;
	localparam logic [2:0] RG_EXECENV = 3'd5;

	typedef enum logic [2:0] {
		KIND_STACK   = 3'd0,
		KIND_LINEAR  = 3'd1,
		KIND_PLT     = 3'd2,
		KIND_VMCTX   = 3'd3,
		KIND_EXECENV = 3'd4,
		KIND_OTHER   = 3'd5
	} kind_t;

	// Input transfer payload, last declared field in the lowest bits.
	typedef struct packed {
		logic        pad;
		logic [2:0]  size_shift;
		logic        store_op;
		logic [63:0] pc_addr;
		logic [63:0] data_addr;
		logic [63:0] bound_high;
		logic [63:0] bound_low;
		logic [2:0]  region_sel;
	} in_item_t;

	// Result transfer payload, last declared field in the lowest bits.
	typedef struct packed {
		logic [1:0]  pad;
		logic [63:0] store_count;
		logic [63:0] load_count;
		logic [4:0]  access_size;
		logic [63:0] insn_offset;
		logic [63:0] data_offset;
		logic        is_load;
	} out_item_t;

endpackage

FILE: design/memory_access_region_classifier.sv
// Top level of the memory access region classifier.

// The classifier takes one transfer per cycle and returns at most one result per
// transfer: the transfer is held in the input register, where all region compares and
// offset subtractions run in parallel, and its result is then held in the result
// register. A region update or a dropped access leaves the input register without a
// result. The input side stalls only while the result register is full and not being
// taken, since region bounds and counters must be applied in transfer order. Address
// fields on the ports are 64 bits; only the low ADDR_WIDTH bits are used, and offsets
// come back zero-extended. Counters are always 64 bits and wrap.
`include "memory_access_region_classifier_defines.svh"

module memory_access_region_classifier #(
	parameter int ADDR_WIDTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// region_sel, bound_low, bound_high, data_addr, pc_addr, store_op, size_shift
	input  logic [marc_pkg::IN_TDATA_W-1:0]     s_tdata,
	// req_type
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// is_load, data_offset, insn_offset, access_size, load_count, store_count
	output logic [marc_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// access_kind
	output marc_pkg::kind_t                     m_tuser
);
	import marc_pkg::*;

	typedef logic [ADDR_WIDTH-1:0] addr_t;

	function automatic logic in_region(addr_t a, addr_t lo, addr_t hi);
		return (a >= lo) && (a <= hi);
	endfunction

	in_item_t in_item;

	logic       valid_s1;
	logic       req_s1;
	logic [2:0] sel_s1;
	addr_t      blow_s1;
	addr_t      bhigh_s1;
	addr_t      daddr_s1;
	addr_t      iaddr_s1;
	logic       store_s1;
	logic [2:0] shift_s1;

	addr_t       region_low_q  [NUM_REGIONS];
	addr_t       region_high_q [NUM_REGIONS];
	logic [63:0] loads_q;
	logic [63:0] stores_q;

	logic      m_valid_q;
	out_item_t out_q;
	kind_t     kind_q;

	logic  code_blank, vmctx_blank;
	logic  hit_code_i, hit_plt_i;
	logic  hit_stack, hit_linear, hit_vmctx, hit_execenv;
	logic  emit, out_free, adv, res_load, region_wr;
	addr_t off_stack, off_linear, off_vmctx, off_execenv, off_code_i, off_plt_i;
	addr_t doff, ioff;
	kind_t kind;
	logic [63:0] loads_inc, stores_inc;
	out_item_t res;

	assign in_item = in_item_t'(s_tdata);

	// Region checks and offsets, all in parallel.
	assign code_blank  = (region_low_q[RG_CODE] == '0) && (region_high_q[RG_CODE] == '0);
	assign vmctx_blank = (region_low_q[RG_VMCTX] == '0) && (region_high_q[RG_VMCTX] == '0);

	assign hit_code_i  = in_region(iaddr_s1, region_low_q[RG_CODE], region_high_q[RG_CODE]);
	assign hit_plt_i   = in_region(iaddr_s1, region_low_q[RG_PLT], region_high_q[RG_PLT]);
	assign hit_stack   = in_region(daddr_s1, region_low_q[RG_STACK], region_high_q[RG_STACK]);
	assign hit_linear  = in_region(daddr_s1, region_low_q[RG_LINEAR], region_high_q[RG_LINEAR]);
	assign hit_vmctx   = in_region(daddr_s1, region_low_q[RG_VMCTX], region_high_q[RG_VMCTX]);
	assign hit_execenv = in_region(daddr_s1, region_low_q[RG_EXECENV],
		region_high_q[RG_EXECENV]);

	assign off_stack   = daddr_s1 - region_low_q[RG_STACK];
	assign off_linear  = daddr_s1 - region_low_q[RG_LINEAR];
	assign off_vmctx   = daddr_s1 - region_low_q[RG_VMCTX];
	assign off_execenv = daddr_s1 - region_low_q[RG_EXECENV];
	assign off_code_i  = iaddr_s1 - region_low_q[RG_CODE];
	assign off_plt_i   = iaddr_s1 - region_low_q[RG_PLT];

	always_comb begin
		kind = KIND_OTHER;
		doff = daddr_s1;
		ioff = off_code_i;
		priority if (hit_stack) begin
			kind = KIND_STACK;
			doff = off_stack;
		end else if (hit_linear) begin
			kind = KIND_LINEAR;
			doff = off_linear;
		end else if (hit_plt_i) begin
			kind = KIND_PLT;
			ioff = off_plt_i;
		end else if (hit_vmctx) begin
			kind = KIND_VMCTX;
			doff = off_vmctx;
		end else if (hit_execenv) begin
			kind = KIND_EXECENV;
			doff = off_execenv;
		end else begin
			kind = KIND_OTHER;
		end
	end

	assign loads_inc  = loads_q + 64'd1;
	assign stores_inc = stores_q + 64'd1;

	always_comb begin
		res             = '0;
		res.is_load     = !store_s1;
		res.data_offset = 64'(doff);
		res.insn_offset = 64'(ioff);
		res.access_size = 5'd1 << shift_s1;
		res.load_count  = store_s1 ? loads_q : loads_inc;
		res.store_count = store_s1 ? stores_inc : stores_q;
	end

	// Handshake: the held item leaves when it has no result or the result register frees.
	assign emit      = valid_s1 && (req_s1 == REQ_ACCESS) && !code_blank && !vmctx_blank &&
		(hit_code_i || hit_plt_i);
	assign out_free  = !m_valid_q || m_tready;
	assign adv       = valid_s1 && (!emit || out_free);
	assign res_load  = emit && out_free;
	assign region_wr = adv && (req_s1 == REQ_UPDATE) && (sel_s1 < 3'(NUM_REGIONS));
	assign s_tready  = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1   <= s_tuser;
			sel_s1   <= in_item.region_sel;
			blow_s1  <= in_item.bound_low[ADDR_WIDTH-1:0];
			bhigh_s1 <= in_item.bound_high[ADDR_WIDTH-1:0];
			daddr_s1 <= in_item.data_addr[ADDR_WIDTH-1:0];
			iaddr_s1 <= in_item.pc_addr[ADDR_WIDTH-1:0];
			store_s1 <= in_item.store_op;
			shift_s1 <= in_item.size_shift;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGIONS; i++) begin
				region_low_q[i]  <= '0;
				region_high_q[i] <= '0;
			end
		end else if (region_wr) begin
			region_low_q[sel_s1]  <= blow_s1;
			region_high_q[sel_s1] <= bhigh_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loads_q  <= '0;
			stores_q <= '0;
		end else if (res_load) begin
			loads_q  <= res.load_count;
			stores_q <= res.store_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q  <= res;
			kind_q <= kind;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_q);
	assign m_tuser  = kind_q;

	`MARC_ASSERT_NOW(a_update_no_result, valid_s1 && (req_s1 == REQ_UPDATE), !res_load)
	`MARC_ASSERT_NOW(a_load_needs_room, res_load, out_free)
	`MARC_ASSERT_NEXT(a_counts_hold, !res_load, $stable(loads_q) && $stable(stores_q))
	`MARC_ASSERT_NEXT(a_held_item_stable, valid_s1 && !adv,
		valid_s1 && $stable(daddr_s1) && $stable(req_s1) && $stable(iaddr_s1))
	`MARC_ASSERT_NEXT(a_result_shown, res_load, m_tvalid)

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the memory access region classifier.
module tb_top;
	import marc_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int RANDOM_ITEMS_PER_PHASE = 300;

	// Selector values that name no region and must leave the bounds alone.
	localparam logic [2:0] SEL_SPARE_LO = 3'd6;
	localparam logic [2:0] SEL_SPARE_HI = 3'd7;

	typedef struct {
		kind_t     kind;
		out_item_t body;
	} classification_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	kind_t                  m_tuser;

	// Shadow copy of the region table and the access counters.
	logic [63:0] region_lo [NUM_REGIONS] = '{default: '0};
	logic [63:0] region_hi [NUM_REGIONS] = '{default: '0};
	logic [63:0] loads_tally = '0;
	logic [63:0] stores_tally = '0;

	classification_t classifications[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	memory_access_region_classifier u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic bit in_region(logic [2:0] r, logic [63:0] a);
		return a >= region_lo[r] && a <= region_hi[r];
	endfunction

	function automatic bit region_blank(logic [2:0] r);
		return region_lo[r] == '0 && region_hi[r] == '0;
	endfunction

	function automatic in_item_t make_update(logic [2:0] sel, logic [63:0] lo, logic [63:0] hi);
		in_item_t it;
		it.pad        = 1'b0;
		it.region_sel = sel;
		it.bound_low  = lo;
		it.bound_high = hi;
		it.data_addr  = rand64();
		it.pc_addr    = rand64();
		it.store_op   = 1'($urandom_range(1));
		it.size_shift = 3'($urandom_range(7));
		return it;
	endfunction

	function automatic in_item_t make_access(logic [63:0] data, logic [63:0] insn,
			logic store, logic [2:0] shift);
		in_item_t it;
		it.pad        = 1'b0;
		it.region_sel = 3'($urandom_range(7));
		it.bound_low  = rand64();
		it.bound_high = rand64();
		it.data_addr  = data;
		it.pc_addr    = insn;
		it.store_op   = store;
		it.size_shift = shift;
		return it;
	endfunction

	// Applies one accepted transfer to the shadow state and queues the record it yields.
	function automatic void classify_item(logic req, in_item_t it);
		classification_t res;
		if (req == REQ_UPDATE) begin
			if (it.region_sel < NUM_REGIONS) begin
				region_lo[it.region_sel] = it.bound_low;
				region_hi[it.region_sel] = it.bound_high;
			end
			return;
		end
		if (region_blank(RG_CODE) || region_blank(RG_VMCTX))
			return;
		if (!in_region(RG_CODE, it.pc_addr) && !in_region(RG_PLT, it.pc_addr))
			return;
		if (it.store_op)
			stores_tally++;
		else
			loads_tally++;
		res.body             = '0;
		res.body.is_load     = !it.store_op;
		res.body.data_offset = it.data_addr;
		res.body.insn_offset = it.pc_addr - region_lo[RG_CODE];
		res.body.access_size = 5'(32'd1 << it.size_shift);
		res.body.load_count  = loads_tally;
		res.body.store_count = stores_tally;
		if (in_region(RG_STACK, it.data_addr)) begin
			res.kind = KIND_STACK;
			res.body.data_offset = it.data_addr - region_lo[RG_STACK];
		end else if (in_region(RG_LINEAR, it.data_addr)) begin
			res.kind = KIND_LINEAR;
			res.body.data_offset = it.data_addr - region_lo[RG_LINEAR];
		end else if (in_region(RG_PLT, it.pc_addr)) begin
			res.kind = KIND_PLT;
			res.body.insn_offset = it.pc_addr - region_lo[RG_PLT];
		end else if (in_region(RG_VMCTX, it.data_addr)) begin
			res.kind = KIND_VMCTX;
			res.body.data_offset = it.data_addr - region_lo[RG_VMCTX];
		end else if (in_region(RG_EXECENV, it.data_addr)) begin
			res.kind = KIND_EXECENV;
			res.body.data_offset = it.data_addr - region_lo[RG_EXECENV];
		end else begin
			res.kind = KIND_OTHER;
		end
		classifications.push_back(res);
	endfunction

	// Holds one item on the input side until it is taken, idling first at random.
	task automatic send_item(logic req, in_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= it;
		do
			@(posedge clk);
		while (!s_tready);
		classify_item(req, it);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (classifications.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		classification_t want;
		out_item_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (classifications.size() == 0) begin
				$error("result transfer with nothing pending: kind %0d", m_tuser);
				mismatch_count++;
			end else begin
				want = classifications.pop_front();
				check_field("access_kind", 64'(want.kind), 64'(m_tuser));
				check_field("is_load", 64'(want.body.is_load), 64'(got.is_load));
				check_field("data_offset", want.body.data_offset, got.data_offset);
				check_field("insn_offset", want.body.insn_offset, got.insn_offset);
				check_field("access_size", 64'(want.body.access_size), 64'(got.access_size));
				check_field("load_count", want.body.load_count, got.load_count);
				check_field("store_count", want.body.store_count, got.store_count);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Mostly small regions, some wide or full-range, a few inverted or blank.
	function automatic void pick_range(output logic [63:0] lo, output logic [63:0] hi);
		int unsigned pick;
		pick = $urandom_range(99);
		lo = rand64();
		if (pick < 70) begin
			hi = lo + 64'($urandom_range(4095));
		end else if (pick < 85) begin
			hi = lo + {32'h0, $urandom};
		end else if (pick < 92) begin
			lo = '0;
			hi = '1;
		end else if (pick < 96) begin
			hi = lo - 64'd1 - 64'($urandom_range(15));
		end else begin
			lo = '0;
			hi = '0;
		end
	endfunction

	// An address inside the region most of the time, its edges and neighbors otherwise.
	function automatic logic [63:0] addr_near(logic [2:0] r);
		logic [63:0] span;
		int unsigned pick;
		pick = $urandom_range(99);
		span = region_hi[r] - region_lo[r] + 64'd1;
		if (pick < 8)
			return region_lo[r];
		if (pick < 16)
			return region_hi[r];
		if (pick < 20)
			return region_lo[r] - 64'd1;
		if (pick < 24)
			return region_hi[r] + 64'd1;
		if (span == '0)
			return rand64();
		return region_lo[r] + rand64() % span;
	endfunction

	task automatic send_random_layout();
		logic [63:0] lo;
		logic [63:0] hi;
		for (int r = 0; r < NUM_REGIONS; r++) begin
			pick_range(lo, hi);
			// Now and then let linear memory overlap the stack to exercise priority.
			if (r == RG_LINEAR && $urandom_range(3) == 0) begin
				lo = region_lo[RG_STACK] + 64'($urandom_range(255));
				hi = lo + 64'($urandom_range(65535));
			end
			send_item(REQ_UPDATE, make_update(3'(r), lo, hi));
		end
	endtask

	task automatic send_random_access();
		logic [63:0] insn;
		logic [63:0] data;
		logic [2:0] shift;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 65)
			insn = addr_near(RG_CODE);
		else if (pick < 90)
			insn = addr_near(RG_PLT);
		else
			insn = rand64();
		pick = $urandom_range(99);
		if (pick < 20)
			data = addr_near(RG_STACK);
		else if (pick < 40)
			data = addr_near(RG_LINEAR);
		else if (pick < 55)
			data = addr_near(RG_VMCTX);
		else if (pick < 70)
			data = addr_near(RG_EXECENV);
		else if (pick < 80)
			data = addr_near(RG_CODE);
		else if (pick < 85)
			data = addr_near(RG_PLT);
		else
			data = rand64();
		shift = ($urandom_range(9) != 0) ? 3'($urandom_range(4)) : 3'($urandom_range(5, 7));
		send_item(REQ_ACCESS, make_access(data, insn, 1'($urandom_range(1)), shift));
	endtask

	task automatic test_drop_rules();
		// Nothing configured yet, so the code region is blank.
		send_item(REQ_ACCESS, make_access(64'h7000_0010, 64'h4000_0100, 1'b0, 3'd2));
		send_item(REQ_UPDATE, make_update(RG_CODE, 64'h4000_0000, 64'h4000_FFFF));
		send_item(REQ_ACCESS, make_access(64'h7000_0010, 64'h4000_0100, 1'b1, 3'd2));
		send_item(REQ_UPDATE, make_update(RG_VMCTX, 64'h7000_0000, 64'h7000_0FFF));
		send_item(REQ_ACCESS, make_access(64'h7000_0010, 64'h5000_0000, 1'b0, 3'd3));
		// An untouched plt region still spans address zero.
		send_item(REQ_ACCESS, make_access(64'h7000_0010, 64'h0, 1'b0, 3'd0));
	endtask

	task automatic test_region_priority();
		// The plt sits below the code region, so code-relative offsets wrap.
		send_item(REQ_UPDATE, make_update(RG_PLT, 64'h3FFF_0000, 64'h3FFF_00FF));
		send_item(REQ_UPDATE, make_update(RG_STACK, 64'h7FFF_0000, 64'h7FFF_FFFF));
		send_item(REQ_UPDATE, make_update(RG_LINEAR, 64'h7FFF_8000, 64'h1_7FFF_FFFF));
		send_item(REQ_UPDATE, make_update(RG_EXECENV, 64'h7000_0800, 64'h7000_1FFF));
		send_item(REQ_ACCESS, make_access(64'h7FFF_8010, 64'h3FFF_0040, 1'b1, 3'd3));
		send_item(REQ_ACCESS, make_access(64'h1_0000_0000, 64'h4000_FFFF, 1'b0, 3'd4));
		send_item(REQ_ACCESS, make_access(64'h10, 64'h3FFF_00FF, 1'b1, 3'd1));
		send_item(REQ_ACCESS, make_access(64'h7000_0900, 64'h4000_0000, 1'b0, 3'd0));
		send_item(REQ_ACCESS, make_access(64'h7000_1FFF, 64'h4000_0008, 1'b0, 3'd2));
		send_item(REQ_ACCESS, make_access('1, 64'h4000_0004, 1'b1, 3'd4));
	endtask

	task automatic test_odd_items();
		send_item(REQ_UPDATE, make_update(SEL_SPARE_LO, '0, '1));
		send_item(REQ_UPDATE, make_update(SEL_SPARE_HI, '0, '1));
		send_item(REQ_ACCESS, make_access(64'h7FFF_0000, 64'h4000_0200, 1'b0, 3'd5));
		// Low bound above high bound: the region matches nothing.
		send_item(REQ_UPDATE, make_update(RG_EXECENV, 64'h7000_9000, 64'h7000_8000));
		send_item(REQ_ACCESS, make_access(64'h7000_8800, 64'h4000_0300, 1'b1, 3'd7));
		send_item(REQ_UPDATE, make_update(RG_CODE, '0, '1));
		send_item(REQ_ACCESS, make_access('1, '1, 1'b1, 3'd6));
		send_item(REQ_UPDATE, make_update(RG_VMCTX, '0, '0));
		send_item(REQ_ACCESS, make_access(64'h7FFF_0010, 64'h4000_0000, 1'b0, 3'd1));
	endtask

	task automatic test_random_traffic(int idle, int stall);
		int unsigned pick;
		idle_pct = idle;
		stall_pct = stall;
		send_random_layout();
		for (int i = 0; i < RANDOM_ITEMS_PER_PHASE; i++) begin
			pick = $urandom_range(99);
			if (pick < 2) begin
				send_random_layout();
			end else if (pick < 8) begin
				logic [63:0] lo;
				logic [63:0] hi;
				pick_range(lo, hi);
				send_item(REQ_UPDATE, make_update(3'($urandom_range(7)), lo, hi));
			end else begin
				send_random_access();
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_drop_rules();
		test_region_priority();
		test_odd_items();
		// The sender holds off here until every pending record has been checked.
		drain_results();
		test_random_traffic(0, 0);
		test_random_traffic(80, 0);
		test_random_traffic(0, 80);
		test_random_traffic(37, 37);
		stall_pct = 0;
		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
